/* rtl/rtt_pkg.sv */
package rtt_pkg;

  localparam int SLOTS_DEF = 8;

  localparam logic [15:0] CLOCK_KHZ_RST = 16'd16000;
  localparam logic [7:0]  INF_CODE_RST  = 8'd255;

  localparam logic CMD_ELAPSE = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  localparam logic REG_CLOCK_KHZ = 1'b0;
  localparam logic REG_INF_CODE  = 1'b1;

  localparam logic [15:0] MIN_START = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPACT,
    ST_AGE,
    ST_APPEND,
    ST_SCHED
  } state_t;

  typedef struct packed {
    logic take;          // latch input item
    logic walk_clear;    // reset walk pointers and minimum
    logic compact_step;
    logic compact_done;
    logic age_step;
    logic zero_elapsed;  // age by zero from now on
    logic append;
    logic set_full;
    logic sched_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_add;
    logic walk_end;
    logic full;
    logic fire;
    logic out_ok;
  } dp_status_t;

endpackage

/* rtl/rtt_ctrl.sv */
module rtt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtt_pkg::dp_status_t st,
  output rtt_pkg::ctrl_cmd_t  cmd_o
);

  rtt_pkg::state_t state, state_next;
  logic second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rtt_pkg::ST_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    second_next = second;
    case (state)
      rtt_pkg::ST_IDLE: begin
        if (in_valid) begin
          second_next = 1'b0;
          state_next  = rtt_pkg::ST_COMPACT;
        end
      end
      rtt_pkg::ST_COMPACT: begin
        if (!st.is_add || st.walk_end) state_next = rtt_pkg::ST_AGE;
      end
      rtt_pkg::ST_AGE: begin
        if (st.walk_end) begin
          if (!st.is_add || second || st.full) state_next = rtt_pkg::ST_SCHED;
          else state_next = rtt_pkg::ST_APPEND;
        end
      end
      rtt_pkg::ST_APPEND: begin
        second_next = 1'b1;
        state_next  = rtt_pkg::ST_AGE;
      end
      rtt_pkg::ST_SCHED: begin
        if (st.out_ok) state_next = rtt_pkg::ST_IDLE;
      end
      default: state_next = rtt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_stall = 1'b1;
    case (state)
      rtt_pkg::ST_IDLE: begin
        in_stall         = 1'b0;
        cmd_o.take       = in_valid;
        cmd_o.walk_clear = in_valid;
      end
      rtt_pkg::ST_COMPACT: begin
        if (!st.is_add) begin
          cmd_o.walk_clear = 1'b1;
        end else if (st.walk_end) begin
          cmd_o.compact_done = 1'b1;
          cmd_o.walk_clear   = 1'b1;
        end else begin
          cmd_o.compact_step = 1'b1;
        end
      end
      rtt_pkg::ST_AGE: begin
        if (st.walk_end) begin
          cmd_o.set_full = st.is_add && !second && st.full;
        end else if (!st.fire || st.out_ok) begin
          cmd_o.age_step = 1'b1;
        end
      end
      rtt_pkg::ST_APPEND: begin
        cmd_o.append       = 1'b1;
        cmd_o.zero_elapsed = 1'b1;
        cmd_o.walk_clear   = 1'b1;
      end
      rtt_pkg::ST_SCHED: begin
        cmd_o.sched_load = st.out_ok;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/rtt_dp.sv */
module rtt_dp #(
  parameter int SLOTS = rtt_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rtt_pkg::ctrl_cmd_t  cmd_i,
  output rtt_pkg::dp_status_t st,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                cmd,
  input  logic [15:0]         elapsed_ticks,
  input  logic [15:0]         current_count,
  input  logic [15:0]         delay_ms,
  input  logic [7:0]          repeat_count,
  input  logic [7:0]          command_code,
  input  logic [15:0]         data_tag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output logic [7:0]          fired_command,
  output logic [15:0]         fired_tag,
  output logic [15:0]         compare_value,
  output logic                table_full,
  output logic                last
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  logic [15:0] clock_khz;
  logic [7:0]  inf_code;

  logic [23:0] rem_mem    [SLOTS];
  logic [22:0] period_mem [SLOTS];
  logic [7:0]  rounds_mem [SLOTS];
  logic [7:0]  cmd_mem    [SLOTS];
  logic [15:0] tag_mem    [SLOTS];

  logic [CW-1:0] active, idx, dst;
  logic          is_add, full;
  logic [15:0]   elapsed, now, delay, tag_r;
  logic [7:0]    rep_r, code_r;
  logic [31:0]   prod;
  logic [15:0]   lowest;

  logic          out_ok;
  logic [IW-1:0] ix, dx, ax;
  logic [23:0]   rem_s;
  logic [7:0]    rnd_s, rnd_new;
  logic [24:0]   diff;
  logic [23:0]   r, r_fin, v;
  logic          fire;

  assign out_ok = !out_valid || !out_stall;
  assign ix = idx[IW-1:0];
  assign dx = dst[IW-1:0];
  assign ax = active[IW-1:0];

  always_comb begin
    rem_s = rem_mem[ix];
    rnd_s = rounds_mem[ix];
    diff  = {rem_s[23], rem_s} - {9'd0, elapsed};
    // saturate at the most negative value
    if (diff[24] && !diff[23]) r = 24'h800000;
    else r = diff[23:0];
    fire = (rnd_s != 8'd0) && (r[23] || (r == 24'd0));
    rnd_new = rnd_s;
    if (fire && rnd_s != inf_code) rnd_new = rnd_s - 8'd1;
    r_fin = r;
    if (fire && rnd_new != 8'd0) r_fin = r + {1'b0, period_mem[ix]};
    v = r_fin[23] ? 24'd0 : r_fin;
  end

  assign st.is_add   = is_add;
  assign st.walk_end = (idx == active);
  assign st.full     = (active >= SLOTS_C);
  assign st.fire     = fire;
  assign st.out_ok   = out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_khz <= rtt_pkg::CLOCK_KHZ_RST;
      inf_code  <= rtt_pkg::INF_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rtt_pkg::REG_CLOCK_KHZ: clock_khz <= cfg_data;
        rtt_pkg::REG_INF_CODE:  inf_code  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= delay * clock_khz;
    if (cmd_i.take) begin
      is_add  <= cmd;
      elapsed <= elapsed_ticks;
      now     <= current_count;
      delay   <= delay_ms;
      rep_r   <= repeat_count;
      code_r  <= command_code;
      tag_r   <= data_tag;
      full    <= 1'b0;
    end
    if (cmd_i.zero_elapsed) elapsed <= 16'd0;
    if (cmd_i.set_full) full <= 1'b1;
    if (cmd_i.walk_clear) begin
      idx    <= '0;
      dst    <= '0;
      lowest <= rtt_pkg::MIN_START;
    end
    if (cmd_i.compact_step) begin
      idx <= idx + CW'(1);
      if (rnd_s != 8'd0) begin
        rem_mem[dx]    <= rem_mem[ix];
        period_mem[dx] <= period_mem[ix];
        rounds_mem[dx] <= rnd_s;
        cmd_mem[dx]    <= cmd_mem[ix];
        tag_mem[dx]    <= tag_mem[ix];
        dst <= dst + CW'(1);
      end
    end
    if (cmd_i.age_step) begin
      idx <= idx + CW'(1);
      if (rnd_s != 8'd0) begin
        rem_mem[ix]    <= r_fin;
        rounds_mem[ix] <= rnd_new;
        if (rnd_new != 8'd0 && {8'd0, lowest} > v) lowest <= v[15:0];
      end
    end
    if (cmd_i.append) begin
      period_mem[ax] <= {1'b0, prod[31:10]};
      rem_mem[ax]    <= {2'b00, prod[31:10]};
      rounds_mem[ax] <= rep_r;
      cmd_mem[ax]    <= code_r;
      tag_mem[ax]    <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd_i.compact_done) begin
      active <= dst;
    end else if (cmd_i.append) begin
      active <= active + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_i.sched_load || (cmd_i.age_step && fire)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.age_step && fire) begin
      kind          <= rtt_pkg::KIND_FIRE;
      fired_command <= cmd_mem[ix];
      fired_tag     <= tag_mem[ix];
      compare_value <= 16'd0;
      table_full    <= 1'b0;
      last          <= 1'b0;
    end else if (cmd_i.sched_load) begin
      kind          <= rtt_pkg::KIND_SCHED;
      fired_command <= 8'd0;
      fired_tag     <= 16'd0;
      compare_value <= (now >= lowest) ? now + 16'd2 : lowest;
      table_full    <= full;
      last          <= 1'b1;
    end
  end

endmodule

/* rtl/repeating_timer_table_core.sv */
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall  | cmd elapsed_ticks current_count delay_ms
//         |           |                    | repeat_count command_code data_tag
// output  | out       | out_valid/out_stall| kind fired_command fired_tag compare_value
//         |           |                    | table_full last
// config  | in        | cfg_we             | cfg_index cfg_data
// Elapse item: one aging pass over the slot table; add item: compaction, then one or two
// aging passes. The walk visits one slot a cycle, but an aging step that fires waits for the output.
// Each fire event and the schedule result wait while the output register is held.
// Reset (rst, synchronous) empties the table; slot contents are not cleared.
// A new item is taken once the schedule result is in the output register.
module repeating_timer_table_core #(
  parameter int SLOTS = rtt_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [15:0] elapsed_ticks,
  input  logic [15:0] current_count,
  input  logic [15:0] delay_ms,
  input  logic [7:0]  repeat_count,
  input  logic [7:0]  command_code,
  input  logic [15:0] data_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  fired_command,
  output logic [15:0] fired_tag,
  output logic [15:0] compare_value,
  output logic        table_full,
  output logic        last
);

  rtt_pkg::ctrl_cmd_t  ccmd;
  rtt_pkg::dp_status_t dst;

  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (dst),
    .cmd_o    (ccmd)
  );

  rtt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd_i         (ccmd),
    .st            (dst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .elapsed_ticks (elapsed_ticks),
    .current_count (current_count),
    .delay_ms      (delay_ms),
    .repeat_count  (repeat_count),
    .command_code  (command_code),
    .data_tag      (data_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .fired_command (fired_command),
    .fired_tag     (fired_tag),
    .compare_value (compare_value),
    .table_full    (table_full),
    .last          (last)
  );

endmodule

/* rtl/rtt_checker.sv */
module rtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [15:0] compare_value,
  input logic        table_full,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("output item dropped while held");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(compare_value)) else $error("held payload changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("item taken while busy");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == last)) else $error("last flag not on schedule result");

  a_full_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> kind) else $error("full flag on fire event");

endmodule

bind repeating_timer_table_core rtt_checker u_rtt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .kind          (kind),
  .compare_value (compare_value),
  .table_full    (table_full),
  .last          (last)
);

/* bench/tb_repeating_timer_table_core.sv */
`timescale 1ns / 100ps

module tb_repeating_timer_table_core;

  localparam int SLOTS = rtt_pkg::SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int REM_FLOOR = -8388608;

  typedef struct packed {
    logic        kind;
    logic [7:0]  fired_command;
    logic [15:0] fired_tag;
    logic [15:0] compare_value;
    logic        table_full;
    logic        last;
  } timer_event_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [15:0] elapsed_ticks;
  logic [15:0] current_count;
  logic [15:0] delay_ms;
  logic [7:0]  repeat_count;
  logic [7:0]  command_code;
  logic [15:0] data_tag;
  logic        out_valid;
  logic        out_stall;
  logic        kind;
  logic [7:0]  fired_command;
  logic [15:0] fired_tag;
  logic [15:0] compare_value;
  logic        table_full;
  logic        last;

  repeating_timer_table_core #(.SLOTS(SLOTS)) u_dut (.*);

  // Shadow timer table
  int          tm_remaining [SLOTS];
  int unsigned tm_period [SLOTS];
  logic [7:0]  tm_rounds [SLOTS];
  logic [7:0]  tm_command [SLOTS];
  logic [15:0] tm_tag [SLOTS];
  int          tm_active;
  logic [15:0] sh_clock_khz;
  logic [7:0]  sh_inf_code;

  timer_event_t expected_events[$];
  int  mismatch_count;
  int  cycle_count;
  bit  idle_sender;
  bit  idle_receiver;
  int  hold_receiver;
  int  long_hold;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** repeating_timer_table_core: FAILED **");
      $finish;
    end
  end

  function automatic void push_fire(logic [7:0] c, logic [15:0] t);
    timer_event_t ev;
    ev = '0;
    ev.kind = rtt_pkg::KIND_FIRE;
    ev.fired_command = c;
    ev.fired_tag = t;
    expected_events.push_back(ev);
  endfunction

  // Age live timers; queue fire events; return the schedule minimum.
  function automatic int age_timers(int unsigned ticks);
    int lowest;
    int r;
    int v;
    lowest = 65535;
    for (int i = 0; i < tm_active; i++) begin
      if (tm_rounds[i] == 0) continue;
      r = tm_remaining[i] - int'(ticks);
      if (r < REM_FLOOR) r = REM_FLOOR;
      if (r <= 0) begin
        push_fire(tm_command[i], tm_tag[i]);
        if (tm_rounds[i] != sh_inf_code) tm_rounds[i] = tm_rounds[i] - 8'd1;
        if (tm_rounds[i] != 0) r = r + int'(tm_period[i]);
      end
      tm_remaining[i] = r;
      if (tm_rounds[i] != 0) begin
        v = (r < 0) ? 0 : r;
        if (v < lowest) lowest = v;
      end
    end
    return lowest;
  endfunction

  function automatic void drop_spent();
    int keep;
    keep = 0;
    for (int i = 0; i < tm_active; i++) begin
      if (tm_rounds[i] == 0) continue;
      tm_remaining[keep] = tm_remaining[i];
      tm_period[keep] = tm_period[i];
      tm_rounds[keep] = tm_rounds[i];
      tm_command[keep] = tm_command[i];
      tm_tag[keep] = tm_tag[i];
      keep++;
    end
    tm_active = keep;
  endfunction

  function automatic void predict_item(logic c, logic [15:0] el, logic [15:0] now,
                                       logic [15:0] dly, logic [7:0] rep,
                                       logic [7:0] code, logic [15:0] tg);
    int lowest;
    logic full;
    logic [33:0] prod;
    timer_event_t ev;
    full = 1'b0;
    if (c == rtt_pkg::CMD_ELAPSE) begin
      lowest = age_timers(el);
    end else begin
      drop_spent();
      lowest = age_timers(el);
      if (tm_active >= SLOTS) begin
        full = 1'b1;
      end else begin
        prod = dly * sh_clock_khz;
        tm_period[tm_active] = prod[33:10];
        tm_remaining[tm_active] = int'(prod[33:10]);
        tm_rounds[tm_active] = rep;
        tm_command[tm_active] = code;
        tm_tag[tm_active] = tg;
        tm_active++;
        lowest = age_timers(0);
      end
    end
    ev = '0;
    ev.kind = rtt_pkg::KIND_SCHED;
    ev.compare_value = (int'(now) >= lowest) ? now + 16'd2 : lowest[15:0];
    ev.table_full = full;
    ev.last = 1'b1;
    expected_events.push_back(ev);
  endfunction

  task automatic send_item(logic c, logic [15:0] el, logic [15:0] now, logic [15:0] dly,
                           logic [7:0] rep, logic [7:0] code, logic [15:0] tg);
    int gap;
    if (idle_sender && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    elapsed_ticks <= el;
    current_count <= now;
    delay_ms <= dly;
    repeat_count <= rep;
    command_code <= code;
    data_tag <= tg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(c, el, now, dly, rep, code, tg);
  endtask

  task automatic send_random(int add_pct, int max_elapse, int max_delay);
    logic [7:0] rep;
    case ($urandom_range(0, 5))
      0: rep = 8'd0;
      1: rep = sh_inf_code;
      2: rep = 8'($urandom_range(0, 255));
      default: rep = 8'($urandom_range(1, 4));
    endcase
    send_item(($urandom_range(0, 99) < add_pct) ? rtt_pkg::CMD_ADD : rtt_pkg::CMD_ELAPSE,
              16'($urandom_range(0, max_elapse)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, max_delay)), rep, 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rtt_pkg::REG_CLOCK_KHZ) sh_clock_khz = value;
    else sh_inf_code = value[7:0];
  endtask

  // Long hold-off, counted down on its own
  always @(posedge clk) begin
    if (long_hold > 0) long_hold <= long_hold - 1;
  end

  // Receiver: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold > 1) begin
      out_stall <= 1'b1;
    end else if (hold_receiver > 0) begin
      hold_receiver <= hold_receiver - 1;
      out_stall <= (hold_receiver > 1);
    end else if (idle_receiver && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      hold_receiver <= $urandom_range(1, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    timer_event_t got;
    timer_event_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {kind, fired_command, fired_tag, compare_value, table_full, last};
      if (expected_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected kind %0b cmd %h tag %h cmp %h full %0b last %0b",
                     want.kind, want.fired_command, want.fired_tag, want.compare_value,
                     want.table_full, want.last);
            $display("          got      kind %0b cmd %h tag %h cmp %h full %0b last %0b",
                     got.kind, got.fired_command, got.fired_tag, got.compare_value,
                     got.table_full, got.last);
          end
        end
      end
    end
  end

  task automatic test_directed();
    // empty table, current count at both ends
    send_item(rtt_pkg::CMD_ELAPSE, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0);
    send_item(rtt_pkg::CMD_ELAPSE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
    // zero-period repeating timer drives remaining toward the negative floor
    send_item(rtt_pkg::CMD_ADD, 16'd0, 16'd10, 16'd0, 8'd3, 8'h11, 16'h1111);
    send_item(rtt_pkg::CMD_ELAPSE, 16'hFFFF, 16'd5, 16'd0, 8'd0, 8'd0, 16'd0);
    send_item(rtt_pkg::CMD_ADD, 16'd0, 16'd10, 16'd0, 8'hFF, 8'h22, 16'h2222);
    for (int i = 0; i < 4; i++)
      send_item(rtt_pkg::CMD_ELAPSE, 16'hFFFF, 16'd1, 16'd0, 8'd0, 8'd0, 16'd0);
    // zero repeat: spent on arrival
    send_item(rtt_pkg::CMD_ADD, 16'd3, 16'd0, 16'd100, 8'd0, 8'h33, 16'h3333);
    // large delay, period caps out near 2^20 at the reset clock setting
    send_item(rtt_pkg::CMD_ADD, 16'd1, 16'd100, 16'hFFFF, 8'd2, 8'hFF, 16'hFFFF);
    // fill the table, then overflow it
    for (int i = 0; i < 9; i++)
      send_item(rtt_pkg::CMD_ADD, 16'd2, 16'd50, 16'(i + 1), 8'd1, 8'(i), 16'(i * 7));
    send_item(rtt_pkg::CMD_ADD, 16'd0, 16'hFFFF, 16'd5, 8'd1, 8'hAA, 16'hAAAA);
    send_item(rtt_pkg::CMD_ELAPSE, 16'd40000, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0);
    send_item(rtt_pkg::CMD_ELAPSE, 16'd40000, 16'hFFFE, 16'd0, 8'd0, 8'd0, 16'd0);
    wait_drained();
  endtask

  task automatic test_config_settings();
    logic [15:0] clocks [4] = '{16'd1, 16'd65535, 16'd1024, 16'd300};
    logic [7:0]  codes [4]  = '{8'd1, 8'd255, 8'd3, 8'd128};
    for (int p = 0; p < 4; p++) begin
      write_reg(rtt_pkg::REG_CLOCK_KHZ, clocks[p]);
      write_reg(rtt_pkg::REG_INF_CODE, {8'h00, codes[p]});
      for (int i = 0; i < 50; i++) send_random(45, 300, 400);
      wait_drained();
    end
    write_reg(rtt_pkg::REG_CLOCK_KHZ, rtt_pkg::CLOCK_KHZ_RST);
    write_reg(rtt_pkg::REG_INF_CODE, {8'h00, rtt_pkg::INF_CODE_RST});
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 200; i++)
      send_random(40, (i % 10 == 0) ? 65535 : 200, (i % 13 == 0) ? 65535 : 30);
  endtask

  task automatic test_backpressure();
    // hold the receiver while the sender keeps offering items
    @(posedge clk);
    long_hold <= 300;
    for (int i = 0; i < 20; i++) send_random(50, 100, 20);
    wait_drained();
  endtask

  task automatic test_steady();
    idle_sender = 1'b0;
    idle_receiver = 1'b0;
    for (int i = 0; i < 40; i++) send_random(40, 150, 20);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = rtt_pkg::REG_CLOCK_KHZ;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = rtt_pkg::CMD_ELAPSE;
    elapsed_ticks = '0;
    current_count = '0;
    delay_ms = '0;
    repeat_count = '0;
    command_code = '0;
    data_tag = '0;
    hold_receiver = 0;
    long_hold = 0;
    cycle_count = 0;
    mismatch_count = 0;
    idle_sender = 1'b1;
    idle_receiver = 1'b1;
    sh_clock_khz = rtt_pkg::CLOCK_KHZ_RST;
    sh_inf_code = rtt_pkg::INF_CODE_RST;
    tm_active = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_settings();
    test_random_mix();
    test_backpressure();
    test_steady();
    wait_drained();
    if (mismatch_count == 0 && expected_events.size() == 0)
      $display("** repeating_timer_table_core: PASSED **");
    else
      $display("** repeating_timer_table_core: FAILED **");
    $finish;
  end

endmodule

/* repeating_timer_table_core.f */
rtl/rtt_pkg.sv
rtl/rtt_ctrl.sv
rtl/rtt_dp.sv
rtl/repeating_timer_table_core.sv
rtl/rtt_checker.sv
bench/tb_repeating_timer_table_core.sv
